// ===== rtl/pose_residual_ema_table_unit_assert.svh =====
// Assertion macros for the residual table block.
// CHK_SAME: antecedent implies consequent in the same cycle.
// CHK_NEXT: antecedent implies consequent in the next cycle.
`ifndef POSE_RESIDUAL_EMA_TABLE_UNIT_ASSERT_SVH
`define POSE_RESIDUAL_EMA_TABLE_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

`define CHK_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("check failed");

`define CHK_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("check failed");

`else

`define CHK_SAME(label, clk, rst_n, ante, cons)

`define CHK_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/pre_tbl_pkg.sv =====
package pre_tbl_pkg;

  // default geometry
  localparam int JOINT_COUNT_DEF     = 19;
  localparam int COMPONENT_COUNT_DEF = 6;
  localparam int VALUE_WIDTH_DEF     = 24;

  // fixed field widths
  localparam int JOINT_IDX_W = 5;
  localparam int COMP_IDX_W  = 3;
  localparam int GAIN_W      = 17;
  localparam int CONF_W      = 17;
  localparam int BOOST_W     = 15;
  localparam int COUNT_W     = 32;

  // fixed-point constants, 16 fraction bits (gain Q1.16)
  localparam logic [GAIN_W-1:0]  GAIN_RESET  = 17'd11796;  // 0.18
  localparam logic [GAIN_W-1:0]  GAIN_ONE    = 17'd65536;  // 1.0
  localparam logic [CONF_W:0]    CONF_ONE    = 18'd65536;  // 1.0
  localparam logic [BOOST_W-1:0] BOOST_LIMIT = 15'd16384;  // 0.25
  localparam logic [BOOST_W-1:0] BOOST_STEP  = 15'd1311;   // 0.02

  // item operation codes
  typedef enum logic {
    OP_OBSERVE = 1'b0,
    OP_APPLY   = 1'b1
  } op_t;

endpackage

// ===== rtl/pre_in_if.sv =====
interface pre_in_if #(
  parameter int VALUE_WIDTH = pre_tbl_pkg::VALUE_WIDTH_DEF
);
  import pre_tbl_pkg::*;

  logic                          valid;
  logic                          ready;
  logic                          operation;
  logic [JOINT_IDX_W-1:0]        joint_index;
  logic [COMP_IDX_W-1:0]         component_index;
  logic signed [VALUE_WIDTH-1:0] first_value;
  logic signed [VALUE_WIDTH-1:0] second_value;
  logic                          frame_end;
  logic [CONF_W-1:0]             confidence_in;

  modport source (
    output valid, operation, joint_index, component_index, first_value,
           second_value, frame_end, confidence_in,
    input  ready
  );

  modport sink (
    input  valid, operation, joint_index, component_index, first_value,
           second_value, frame_end, confidence_in,
    output ready
  );
endinterface

// ===== rtl/pre_out_if.sv =====
interface pre_out_if #(
  parameter int VALUE_WIDTH = pre_tbl_pkg::VALUE_WIDTH_DEF
);
  import pre_tbl_pkg::*;

  logic                          valid;
  logic                          ready;
  logic signed [VALUE_WIDTH-1:0] result_value;
  logic [CONF_W-1:0]             confidence_out;
  logic [COUNT_W-1:0]            observation_count;
  logic                          last_of_frame;

  modport source (
    output valid, result_value, confidence_out, observation_count, last_of_frame,
    input  ready
  );

  modport sink (
    input  valid, result_value, confidence_out, observation_count, last_of_frame,
    output ready
  );
endinterface

// ===== rtl/pose_residual_ema_table_unit.sv =====
// An accepted beat goes through the multiply and write-back states; write-back waits
//   while the output register holds an untaken result. The table is read at accept and
//   written at write-back; no new item is accepted until the last one is written back.
// A result held in the output register does not block the next accept.
// Reset (rst_n, synchronous, active low) clears the per-entry valid bits at once,
//   so the table reads as zero; boost, frame count and gain return to defaults.
module pose_residual_ema_table_unit #(
  parameter int JOINT_COUNT     = pre_tbl_pkg::JOINT_COUNT_DEF,
  parameter int COMPONENT_COUNT = pre_tbl_pkg::COMPONENT_COUNT_DEF,
  parameter int VALUE_WIDTH     = pre_tbl_pkg::VALUE_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  pre_in_if.sink                         in_chan,
  pre_out_if.source                      out_chan,
  input  logic                           cfg_wr_en,
  input  logic [pre_tbl_pkg::GAIN_W-1:0] cfg_wr_data
);
  import pre_tbl_pkg::*;

`include "pose_residual_ema_table_unit_assert.svh"

  localparam int TABLE_SIZE = JOINT_COUNT * COMPONENT_COUNT;
  localparam int IDX_W      = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
  localparam int DIFF_W     = VALUE_WIDTH + 2;
  localparam int PROD_W     = DIFF_W + GAIN_W + 1;
  localparam int DELTA_W    = PROD_W - 16;
  localparam int SUM_W      = VALUE_WIDTH + 4;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_MUL  = 3'b010,
    ST_WB   = 3'b100
  } state_t;

  // saturate a wide sum to the signed value range
  function automatic logic [VALUE_WIDTH-1:0] sat_value(input logic signed [SUM_W-1:0] v);
    logic [SUM_W-VALUE_WIDTH:0] upper;
    upper = v[SUM_W-1:VALUE_WIDTH-1];
    if (upper == '0 || upper == '1) begin
      return v[VALUE_WIDTH-1:0];
    end else if (v[SUM_W-1]) begin
      return {1'b1, {(VALUE_WIDTH-1){1'b0}}};
    end else begin
      return {1'b0, {(VALUE_WIDTH-1){1'b1}}};
    end
  endfunction

  state_t state_r, state_nxt;

  // item held while it is in flight
  logic                          op_r;
  logic                          fend_r;
  logic                          hit_r;
  logic [IDX_W-1:0]              idx_r;
  logic [CONF_W-1:0]             conf_r;
  logic signed [VALUE_WIDTH-1:0] first_r;
  logic signed [VALUE_WIDTH-1:0] second_r;

  // table memory and its valid bits
  logic [VALUE_WIDTH-1:0]        mem [TABLE_SIZE];
  logic [TABLE_SIZE-1:0]         vld_r;
  logic [VALUE_WIDTH-1:0]        rd_data_r;
  logic                          rd_vld_r;

  logic signed [PROD_W-1:0]      prod_r;
  logic [GAIN_W-1:0]             gain_r;
  logic [BOOST_W-1:0]            boost_r, boost_nxt;
  logic [COUNT_W-1:0]            frames_r, frames_nxt;

  // output register
  logic                          out_valid_r;
  logic [VALUE_WIDTH-1:0]        out_value_r;
  logic [CONF_W-1:0]             out_conf_r;
  logic [COUNT_W-1:0]            out_count_r;
  logic                          out_last_r;

  logic                          in_acc;
  logic                          hit_in;
  logic [31:0]                   idx_wide;
  logic [IDX_W-1:0]              idx_in;
  logic signed [VALUE_WIDTH-1:0] r_cur;
  logic [GAIN_W-1:0]             gain_eff;
  logic signed [DIFF_W-1:0]      d_val;
  logic signed [DELTA_W-1:0]     delta;
  logic signed [SUM_W-1:0]       obs_sum;
  logic signed [SUM_W-1:0]       app_sum;
  logic [VALUE_WIDTH-1:0]        result_nxt;
  logic [CONF_W:0]               conf_sum;
  logic [CONF_W-1:0]             conf_nxt;
  logic                          wb_go;
  logic                          mem_we;
  logic                          fend_obs;

  // input handshake and table index
  assign in_chan.ready = (state_r == ST_IDLE);
  assign in_acc        = in_chan.valid && in_chan.ready;

  always_comb begin
    hit_in   = (32'(in_chan.joint_index) < 32'(JOINT_COUNT)) &&
               (32'(in_chan.component_index) < 32'(COMPONENT_COUNT));
    idx_wide = 32'(in_chan.joint_index) * 32'(COMPONENT_COUNT) +
               32'(in_chan.component_index);
    idx_in   = hit_in ? idx_wide[IDX_W-1:0] : '0;
  end

  // stored residual, zero when never written or index out of range
  assign r_cur = (hit_r && rd_vld_r) ? $signed(rd_data_r) : '0;

  // multiply stage operands
  always_comb begin
    gain_eff = (gain_r > GAIN_ONE) ? GAIN_ONE : gain_r;
    d_val    = DIFF_W'(second_r) - DIFF_W'(first_r) - DIFF_W'(r_cur);
  end

  // write-back stage arithmetic
  always_comb begin
    delta   = $signed(prod_r[PROD_W-1:16]);
    obs_sum = SUM_W'(r_cur) + SUM_W'(delta);
    app_sum = SUM_W'(first_r) + SUM_W'(r_cur);
    if (op_r == OP_APPLY) begin
      result_nxt = sat_value(app_sum);
    end else if (hit_r) begin
      result_nxt = sat_value(obs_sum);
    end else begin
      result_nxt = '0;
    end
    conf_sum = 18'(conf_r) + 18'(boost_r);
    if (op_r == OP_APPLY && fend_r) begin
      conf_nxt = (conf_sum > CONF_ONE) ? GAIN_ONE : conf_sum[CONF_W-1:0];
    end else begin
      conf_nxt = '0;
    end
  end

  assign wb_go    = (state_r == ST_WB) && (!out_valid_r || out_chan.ready);
  assign mem_we   = wb_go && (op_r == OP_OBSERVE) && hit_r;
  assign fend_obs = wb_go && (op_r == OP_OBSERVE) && fend_r;

  // frame-end bookkeeping
  always_comb begin
    boost_nxt  = boost_r;
    frames_nxt = frames_r;
    if (fend_obs) begin
      if (boost_r < BOOST_LIMIT) begin
        boost_nxt = boost_r + BOOST_STEP;
      end
      frames_nxt = frames_r + 32'd1;
    end
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) state_nxt = ST_MUL;
      end
      ST_MUL: begin
        state_nxt = ST_WB;
      end
      ST_WB: begin
        if (wb_go) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // table memory: read at accept, write at write-back
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[idx_r] <= result_nxt;
    end
    if (in_acc) begin
      rd_data_r <= mem[idx_in];
    end
  end

  // item capture, product register and output register
  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r     <= in_chan.operation;
      fend_r   <= in_chan.frame_end;
      hit_r    <= hit_in;
      idx_r    <= idx_in;
      conf_r   <= in_chan.confidence_in;
      first_r  <= in_chan.first_value;
      second_r <= in_chan.second_value;
      rd_vld_r <= vld_r[idx_in];
    end
    if (state_r == ST_MUL) begin
      prod_r <= PROD_W'(d_val) * PROD_W'($signed({1'b0, gain_eff}));
    end
    if (wb_go) begin
      out_value_r <= result_nxt;
      out_conf_r  <= conf_nxt;
      out_count_r <= frames_nxt;
      out_last_r  <= fend_r;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      vld_r       <= '0;
      gain_r      <= GAIN_RESET;
      boost_r     <= '0;
      frames_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      boost_r  <= boost_nxt;
      frames_r <= frames_nxt;
      if (mem_we) begin
        vld_r[idx_r] <= 1'b1;
      end
      if (cfg_wr_en) begin
        gain_r <= cfg_wr_data;
      end
      if (wb_go) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_chan.valid             = out_valid_r;
  assign out_chan.result_value      = out_value_r;
  assign out_chan.confidence_out    = out_conf_r;
  assign out_chan.observation_count = out_count_r;
  assign out_chan.last_of_frame     = out_last_r;

  // checks
  `CHK_SAME(a_state_onehot, clk, rst_n, 1'b1, $onehot(state_r))
  `CHK_NEXT(a_accept_to_mul, clk, rst_n, in_acc, state_r == ST_MUL)
  `CHK_SAME(a_write_in_wb, clk, rst_n, mem_we, state_r == ST_WB && op_r == OP_OBSERVE)
  `CHK_SAME(a_boost_bound, clk, rst_n, 1'b1, boost_r < BOOST_LIMIT + BOOST_STEP)
  `CHK_NEXT(a_result_held, clk, rst_n, out_valid_r && !out_chan.ready, out_valid_r)

endmodule

// ===== tb/tb_pose_residual_ema_table_unit.sv =====
`timescale 1ns / 1ps

module tb_pose_residual_ema_table_unit;
  import pre_tbl_pkg::*;

  localparam int     VW         = VALUE_WIDTH_DEF;
  localparam int     TBL_SIZE   = JOINT_COUNT_DEF * COMPONENT_COUNT_DEF;
  localparam longint VAL_MAX    = (longint'(1) <<< (VW - 1)) - 1;
  localparam longint VAL_MIN    = -VAL_MAX - 1;
  localparam int     QUIET_MAX  = 2000;
  localparam int     HOLD_AFTER = 300;
  localparam int     HOLD_LEN   = 150;
  localparam int     PHASE_LEN  = 200;

  typedef struct packed {
    op_t                    op;
    logic [JOINT_IDX_W-1:0] joint;
    logic [COMP_IDX_W-1:0]  comp;
    logic signed [VW-1:0]   first;
    logic signed [VW-1:0]   second;
    logic                   fend;
    logic [CONF_W-1:0]      conf;
  } pose_item_t;

  typedef struct packed {
    logic signed [VW-1:0] value;
    logic [CONF_W-1:0]    conf;
    logic [COUNT_W-1:0]   count;
    logic                 last;
  } ema_result_t;

  typedef struct packed {
    pose_item_t  stim;
    logic        pinned;
    ema_result_t res;
  } dir_row_t;

  logic clk;
  logic rst_n;
  logic cfg_wr_en;
  logic [GAIN_W-1:0] cfg_wr_data;

  pre_in_if  in_bus ();
  pre_out_if out_bus ();

  pose_residual_ema_table_unit u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_chan     (in_bus),
    .out_chan    (out_bus),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  // shadow of the block state
  longint            resid_tbl [TBL_SIZE];
  int unsigned       boost_q16;
  logic [COUNT_W-1:0] frames_seen;
  logic [GAIN_W-1:0] gain_q16;

  ema_result_t pending_results [$];
  dir_row_t    dir_rows [$];

  // typed-in expectation for the beat currently offered
  bit          pin_on;
  ema_result_t pin_res;

  int burst_left;
  int beats_out;
  int quiet_cycles;
  int fail_cnt;

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint clamp_value(longint v);
    if (v > VAL_MAX) return VAL_MAX;
    if (v < VAL_MIN) return VAL_MIN;
    return v;
  endfunction

  // one element through the residual table, updating the shadow state
  function automatic ema_result_t advance_table(pose_item_t it);
    ema_result_t res;
    bit          hit;
    int unsigned slot;
    longint      r;
    longint      d;
    longint      g;
    longint      nv;
    longint      sum;
    hit  = (it.joint < JOINT_COUNT_DEF) && (it.comp < COMPONENT_COUNT_DEF);
    slot = it.joint * COMPONENT_COUNT_DEF + it.comp;
    r    = hit ? resid_tbl[slot] : 0;
    nv   = 0;
    res.conf = '0;
    res.last = it.fend;
    if (it.op == OP_OBSERVE) begin
      if (hit) begin
        g  = longint'((gain_q16 > GAIN_ONE) ? GAIN_ONE : gain_q16);
        d  = (longint'(it.second) - longint'(it.first)) - r;
        // arithmetic shift floors toward minus infinity
        nv = clamp_value(r + ((d * g) >>> 16));
        resid_tbl[slot] = nv;
      end
      if (it.fend) begin
        if (boost_q16 < BOOST_LIMIT) boost_q16 += BOOST_STEP;
        frames_seen++;
      end
    end else begin
      nv = clamp_value(longint'(it.first) + r);
      if (it.fend) begin
        sum      = longint'(it.conf) + longint'(boost_q16);
        res.conf = (sum > CONF_ONE) ? CONF_W'(CONF_ONE) : CONF_W'(sum);
      end
    end
    res.value = nv[VW-1:0];
    res.count = frames_seen;
    return res;
  endfunction

  function automatic void add_row(op_t op, int j, int c, longint f, longint s, bit fe,
                                  int cf, bit pinned = 0, longint rv = 0, int rc = 0,
                                  longint rn = 0);
    dir_row_t row;
    row.stim.op     = op;
    row.stim.joint  = j[JOINT_IDX_W-1:0];
    row.stim.comp   = c[COMP_IDX_W-1:0];
    row.stim.first  = f[VW-1:0];
    row.stim.second = s[VW-1:0];
    row.stim.fend   = fe;
    row.stim.conf   = cf[CONF_W-1:0];
    row.pinned      = pinned;
    row.res.value   = rv[VW-1:0];
    row.res.conf    = rc[CONF_W-1:0];
    row.res.count   = rn[COUNT_W-1:0];
    row.res.last    = fe;
    dir_rows.push_back(row);
  endfunction

  function automatic logic signed [VW-1:0] rand_value();
    case ($urandom_range(0, 9))
      0:       return VW'(VAL_MAX);
      1:       return VW'(VAL_MIN);
      2, 3:    return VW'($urandom_range(0, 4000) - 2000);
      default: return VW'($urandom());
    endcase
  endfunction

  // mostly in-range elements of the frame's operation; some noise
  function automatic pose_item_t rand_item(op_t op, bit last);
    pose_item_t it;
    it.op   = ($urandom_range(0, 19) == 0) ? op_t'($urandom_range(0, 1)) : op;
    it.fend = last | ($urandom_range(0, 29) == 0);
    if ($urandom_range(0, 19) == 0) begin
      it.joint = JOINT_IDX_W'($urandom_range(0, 31));
      it.comp  = COMP_IDX_W'($urandom_range(0, 7));
    end else if ($urandom_range(0, 1) == 1) begin
      // a few hot entries so residuals settle over many updates
      it.joint = JOINT_IDX_W'($urandom_range(0, 2));
      it.comp  = COMP_IDX_W'($urandom_range(0, COMPONENT_COUNT_DEF - 1));
    end else begin
      it.joint = JOINT_IDX_W'($urandom_range(0, JOINT_COUNT_DEF - 1));
      it.comp  = COMP_IDX_W'($urandom_range(0, COMPONENT_COUNT_DEF - 1));
    end
    it.first = rand_value();
    if ($urandom_range(0, 3) == 0) begin
      it.second = rand_value();
    end else begin
      it.second = it.first + VW'($urandom_range(0, 20000) - 10000);
    end
    it.conf = ($urandom_range(0, 7) == 0) ? CONF_W'($urandom_range(0, 131071))
                                          : CONF_W'($urandom_range(0, 65536));
    return it;
  endfunction

  // sender: one beat, held until taken
  task automatic offer(pose_item_t it, bit pinned, ema_result_t res);
    @(negedge clk);
    in_bus.valid           = 1'b1;
    in_bus.operation       = it.op;
    in_bus.joint_index     = it.joint;
    in_bus.component_index = it.comp;
    in_bus.first_value     = it.first;
    in_bus.second_value    = it.second;
    in_bus.frame_end       = it.fend;
    in_bus.confidence_in   = it.conf;
    pin_on                 = pinned;
    pin_res                = res;
    do @(posedge clk); while (!in_bus.ready);
  endtask

  // bursts of random length with random gaps
  task automatic pace();
    int n;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 30);
      if ($urandom_range(0, 3) != 0) begin
        n = $urandom_range(1, 8);
        repeat (n) begin
          @(negedge clk);
          in_bus.valid = 1'b0;
        end
      end
    end
    burst_left--;
  endtask

  // gain changes only with the block drained
  task automatic write_gain(logic [GAIN_W-1:0] g);
    @(negedge clk);
    in_bus.valid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_wr_en   = 1'b1;
    cfg_wr_data = g;
    gain_q16    = g;
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  task automatic run_frames(int n_items);
    pose_item_t  it;
    ema_result_t none;
    op_t         op;
    int          left;
    int          flen;
    none = '0;
    left = n_items;
    while (left > 0) begin
      flen = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
      if (flen > left) flen = left;
      op = op_t'($urandom_range(0, 1));
      for (int k = 0; k < flen; k++) begin
        it = rand_item(op, k == flen - 1);
        pace();
        offer(it, 1'b0, none);
      end
      left -= flen;
    end
  endtask

  // receiver: rotating stall pattern, plus one long hold-off
  initial begin : rx_pacing
    int  cyc;
    bit  held;
    cyc  = 0;
    held = 0;
    out_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!held && beats_out >= HOLD_AFTER) begin
        held = 1;
        out_bus.ready = 1'b0;
        repeat (HOLD_LEN) @(negedge clk);
      end
      case ((cyc / 97) % 4)
        0:       out_bus.ready = 1'b1;
        1:       out_bus.ready = ($urandom_range(0, 3) != 0);
        2:       out_bus.ready = ((cyc % 5) < 2);
        default: out_bus.ready = 1'($urandom_range(0, 1));
      endcase
      cyc++;
    end
  end

  // accepted beats on both sides
  always @(posedge clk) begin : beat_monitor
    pose_item_t  seen;
    ema_result_t want;
    ema_result_t got;
    bit          moved;
    if (rst_n) begin
      moved = 0;
      if (in_bus.valid && in_bus.ready) begin
        moved       = 1;
        seen.op     = op_t'(in_bus.operation);
        seen.joint  = in_bus.joint_index;
        seen.comp   = in_bus.component_index;
        seen.first  = in_bus.first_value;
        seen.second = in_bus.second_value;
        seen.fend   = in_bus.frame_end;
        seen.conf   = in_bus.confidence_in;
        want = advance_table(seen);
        if (pin_on) want = pin_res;
        pending_results.push_back(want);
      end
      if (out_bus.valid && out_bus.ready) begin
        moved = 1;
        beats_out++;
        got.value = out_bus.result_value;
        got.conf  = out_bus.confidence_out;
        got.count = out_bus.observation_count;
        got.last  = out_bus.last_of_frame;
        if (pending_results.size() == 0) begin
          fail_cnt++;
          if (fail_cnt <= 10)
            $display("unexpected result beat: value %0d conf %0d count %0d last %0b",
                     got.value, got.conf, got.count, got.last);
        end else begin
          want = pending_results.pop_front();
          if (got.value !== want.value || got.conf !== want.conf ||
              got.count !== want.count || got.last !== want.last) begin
            fail_cnt++;
            if (fail_cnt <= 10)
              $display("mismatch (exp/got): value %0d/%0d conf %0d/%0d count %0d/%0d last %0b/%0b",
                       want.value, got.value, want.conf, got.conf,
                       want.count, got.count, want.last, got.last);
          end
        end
      end
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
    end
  end

  // watchdog on stalled traffic
  initial begin : watchdog
    wait (quiet_cycles >= QUIET_MAX);
    $display("tb: failure");
    $finish;
  end

  initial begin : main_flow
    logic [GAIN_W-1:0] gain_plan [7];
    in_bus.valid           = 1'b0;
    in_bus.operation       = OP_OBSERVE;
    in_bus.joint_index     = '0;
    in_bus.component_index = '0;
    in_bus.first_value     = '0;
    in_bus.second_value    = '0;
    in_bus.frame_end       = 1'b0;
    in_bus.confidence_in   = '0;
    cfg_wr_en    = 1'b0;
    cfg_wr_data  = '0;
    pin_on       = 0;
    pin_res      = '0;
    boost_q16    = 0;
    frames_seen  = '0;
    gain_q16     = GAIN_RESET;
    burst_left   = 0;
    beats_out    = 0;
    quiet_cycles = 0;
    fail_cnt     = 0;
    rst_n        = 1'b0;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    // directed rows at the reset gain; fields: op, joint, comp, first, second,
    // frame end, confidence, then a pin flag and the typed-in result where obvious
    add_row(OP_APPLY,   0,  0, 0,       0,       0, 0,      1, 0,       0,     0);
    add_row(OP_APPLY,   18, 5, VAL_MAX, 0,       0, 0,      1, VAL_MAX, 0,     0);
    add_row(OP_APPLY,   0,  0, VAL_MIN, 0,       0, 0,      1, VAL_MIN, 0,     0);
    add_row(OP_APPLY,   5,  1, 100,     0,       1, 65536,  1, 100,     65536, 0);
    // confidence above one clamps
    add_row(OP_APPLY,   5,  1, -100,    0,       1, 131071, 1, -100,    65536, 0);
    add_row(OP_APPLY,   7,  4, 0,       0,       1, 0,      1, 0,       0,     0);
    add_row(OP_OBSERVE, 0,  0, 0,       0,       0, 0,      1, 0,       0,     0);
    // out-of-range entries: no table access, frame effects still apply
    add_row(OP_OBSERVE, 19, 0, 5,       1000,    1, 0,      1, 0,       0,     1);
    add_row(OP_OBSERVE, 31, 7, VAL_MIN, VAL_MAX, 0, 0,      1, 0,       0,     1);
    add_row(OP_APPLY,   3,  6, 12345,   0,       0, 0,      1, 12345,   0,     1);
    add_row(OP_APPLY,   31, 0, -7,      0,       1, 0,      1, -7,      1311,  1);
    add_row(OP_APPLY,   2,  2, 0,       0,       1, 65000,  1, 0,       65536, 1);
    // full-scale error, then saturating applies on both rails
    add_row(OP_OBSERVE, 18, 5, VAL_MIN, VAL_MAX, 0, 0);
    add_row(OP_OBSERVE, 18, 5, VAL_MIN, VAL_MAX, 0, 0);
    add_row(OP_APPLY,   18, 5, VAL_MAX, 0,       0, 0,      1, VAL_MAX, 0,     1);
    add_row(OP_OBSERVE, 1,  2, VAL_MAX, VAL_MIN, 1, 0);
    add_row(OP_APPLY,   1,  2, VAL_MIN, 0,       0, 0,      1, VAL_MIN, 0,     2);
    // small errors: positive truncates to zero, negative floors to -1
    add_row(OP_OBSERVE, 0,  1, -1,      1,       0, 0,      1, 0,       0,     2);
    add_row(OP_OBSERVE, 0,  1, 1,       -1,      0, 0,      1, -1,      0,     2);
    add_row(OP_APPLY,   0,  1, 0,       0,       1, 65536);
    add_row(OP_OBSERVE, 10, 3, 1000,    500000,  1, 0);

    foreach (dir_rows[k]) begin
      pace();
      offer(dir_rows[k].stim, dir_rows[k].pinned, dir_rows[k].res);
    end

    // random frames under a sweep of gains, extremes included
    gain_plan = '{17'd0, GAIN_ONE, 17'h1FFFF, 17'd1, 17'd32768,
                  GAIN_W'($urandom_range(2, 65535)), GAIN_RESET};
    foreach (gain_plan[p]) begin
      write_gain(gain_plan[p]);
      run_frames(PHASE_LEN);
    end

    @(negedge clk);
    in_bus.valid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (fail_cnt == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/pre_tbl_pkg.sv
rtl/pre_in_if.sv
rtl/pre_out_if.sv
rtl/pose_residual_ema_table_unit.sv
tb/tb_pose_residual_ema_table_unit.sv
